[src/bcpt_pkg.sv]
// ----------------------------------------------------------------------------
// Battery charge percent tracker package
// Shared constants, curve tables, cadence table and the curve request type.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpt_pkg;

  localparam int unsigned ProfileCount  = 4;
  localparam int unsigned CurveSegments = 20;
  localparam int unsigned ProfW         = $clog2(ProfileCount);
  localparam int unsigned SegW          = $clog2(CurveSegments);

  localparam logic [15:0] MvInvalidMax = 16'd2399;
  localparam logic [15:0] MvFullMin    = 16'd4341;
  localparam logic [15:0] MvCurveFloor = 16'd3350;
  localparam logic [3:0]  FullReports  = 4'd5;
  localparam logic [3:0]  RefreshSat   = 4'd8;
  localparam logic [7:0]  ElapsedLimit = 8'd180;
  localparam logic [6:0]  StallPctMax  = 7'd98;
  localparam logic [15:0] StallMvMin   = 16'd2400;
  localparam logic [15:0] StallRise    = 16'd35;
  localparam logic [31:0] StallSeconds = 32'd120;
  localparam logic [6:0]  PctInvalid   = 7'd50;
  localparam logic [6:0]  PctFull      = 7'd100;
  localparam logic [6:0]  PctSegment   = 7'd5;
  localparam logic [6:0]  BandOne      = 7'd85;
  localparam logic [6:0]  BandTwo      = 7'd90;
  localparam logic [6:0]  BandThree    = 7'd95;

  // charge status codes
  localparam logic [1:0] ChgNone    = 2'd0;
  localparam logic [1:0] ChgActive  = 2'd1;
  localparam logic [1:0] ChgFull    = 2'd2;
  localparam logic [1:0] ChgUnknown = 2'd3;

  // configuration register indexes
  localparam logic [1:0] RegBatteryType    = 2'd0;
  localparam logic [1:0] RegInitialPercent = 2'd1;
  localparam logic [1:0] RegInitialCharge  = 2'd2;

  localparam logic [15:0] DisTab [ProfileCount][CurveSegments] = '{
    '{16'd3622, 16'd3668, 16'd3682, 16'd3714, 16'd3742, 16'd3769, 16'd3795, 16'd3820,
      16'd3845, 16'd3874, 16'd3902, 16'd3928, 16'd3978, 16'd4027, 16'd4077, 16'd4128,
      16'd4175, 16'd4223, 16'd4262, 16'd4310},
    '{16'd3609, 16'd3669, 16'd3683, 16'd3713, 16'd3742, 16'd3769, 16'd3792, 16'd3816,
      16'd3844, 16'd3870, 16'd3902, 16'd3928, 16'd3977, 16'd4032, 16'd4077, 16'd4127,
      16'd4177, 16'd4225, 16'd4265, 16'd4310},
    '{16'd3531, 16'd3653, 16'd3676, 16'd3704, 16'd3725, 16'd3742, 16'd3758, 16'd3776,
      16'd3797, 16'd3822, 16'd3850, 16'd3885, 16'd3926, 16'd3965, 16'd4024, 16'd4071,
      16'd4124, 16'd4179, 16'd4241, 16'd4310},
    '{16'd3609, 16'd3653, 16'd3677, 16'd3703, 16'd3721, 16'd3739, 16'd3755, 16'd3774,
      16'd3796, 16'd3821, 16'd3852, 16'd3889, 16'd3926, 16'd3967, 16'd4026, 16'd4070,
      16'd4120, 16'd4172, 16'd4232, 16'd4310}
  };

  localparam logic [15:0] ChgTab [ProfileCount][CurveSegments] = '{
    '{16'd3799, 16'd3848, 16'd3887, 16'd3918, 16'd3940, 16'd3960, 16'd3978, 16'd3999,
      16'd4021, 16'd4048, 16'd4078, 16'd4112, 16'd4152, 16'd4200, 16'd4250, 16'd4303,
      16'd4320, 16'd4330, 16'd4340, 16'd4310},
    '{16'd3784, 16'd3809, 16'd3845, 16'd3871, 16'd3885, 16'd3898, 16'd3913, 16'd3933,
      16'd3956, 16'd3983, 16'd4013, 16'd4043, 16'd4074, 16'd4121, 16'd4167, 16'd4211,
      16'd4261, 16'd4318, 16'd4330, 16'd4350},
    '{16'd3799, 16'd3848, 16'd3887, 16'd3918, 16'd3940, 16'd3960, 16'd3978, 16'd3999,
      16'd4021, 16'd4048, 16'd4078, 16'd4112, 16'd4152, 16'd4200, 16'd4250, 16'd4303,
      16'd4320, 16'd4330, 16'd4340, 16'd4350},
    '{16'd3784, 16'd3809, 16'd3845, 16'd3871, 16'd3885, 16'd3898, 16'd3913, 16'd3933,
      16'd3956, 16'd3983, 16'd4013, 16'd4043, 16'd4074, 16'd4121, 16'd4167, 16'd4211,
      16'd4261, 16'd4318, 16'd4330, 16'd4350}
  };

  localparam logic [8:0] StepTab [ProfileCount][4] = '{
    '{9'd38, 9'd60, 9'd108, 9'd480},
    '{9'd48, 9'd72, 9'd144, 9'd480},
    '{9'd38, 9'd60, 9'd108, 9'd480},
    '{9'd48, 9'd72, 9'd144, 9'd480}
  };

  typedef struct packed {
    logic             start;
    logic             charging;
    logic [ProfW-1:0] prof;
    logic [15:0]      mv;
  } curve_req_t;

  function automatic logic [15:0] curve_ub(logic charging, logic [ProfW-1:0] prof,
                                           logic [SegW-1:0] idx);
    logic [15:0] ub;
    if (charging) begin
      ub = ChgTab[prof][idx];
    end else begin
      ub = DisTab[prof][idx];
    end
    return ub;
  endfunction

endpackage

`default_nettype wire

[src/bcpt_curve.sv]
// ----------------------------------------------------------------------------
// Curve walker
// Walks one segment a cycle to find the voltage segment, then interpolates
// with a three-step restoring division (quotient is at most five).
// ----------------------------------------------------------------------------
`default_nettype none

module bcpt_curve (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bcpt_pkg::curve_req_t req_i,
  output logic                 done_o,
  output logic [6:0]           pct_o
);
  import bcpt_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_WALK = 3'b010,
    C_DIV  = 3'b100
  } cstate_e;

  cstate_e          state_q, state_d;
  logic [15:0]      v_q, v_d, lo_q, lo_d, span_q, span_d;
  logic [6:0]       acc_q, acc_d, pct_q, pct_d;
  logic [SegW-1:0]  idx_q, idx_d;
  logic [ProfW-1:0] prof_q, prof_d;
  logic             chg_q, chg_d, done_q, done_d;
  logic [18:0]      rem_q, rem_d;
  logic [2:0]       quo_q, quo_d;
  logic [1:0]       k_q, k_d;

  logic [15:0] hi, top, vin, part, span;
  logic [18:0] shifted, part5;

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    lo_d    = lo_q;
    span_d  = span_q;
    acc_d   = acc_q;
    pct_d   = pct_q;
    idx_d   = idx_q;
    prof_d  = prof_q;
    chg_d   = chg_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    k_d     = k_q;
    done_d  = 1'b0;
    top     = curve_ub(req_i.charging, req_i.prof, SegW'(CurveSegments - 1));
    vin     = (req_i.mv < MvCurveFloor) ? MvCurveFloor : req_i.mv;
    hi      = curve_ub(chg_q, prof_q, idx_q);
    span    = (hi >= lo_q) ? hi - lo_q : 16'd0;
    part    = (v_q >= lo_q) ? v_q - lo_q : 16'd0;
    part5   = {1'b0, part, 2'b00} + {3'b000, part};
    shifted = {3'b000, span_q} << k_q;
    unique case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          v_d     = (vin > top) ? top : vin;
          lo_d    = MvCurveFloor;
          acc_d   = '0;
          idx_d   = '0;
          prof_d  = req_i.prof;
          chg_d   = req_i.charging;
          state_d = C_WALK;
        end
      end
      C_WALK: begin
        if (v_q <= hi) begin
          if (span == 16'd0) begin
            pct_d   = acc_q;
            done_d  = 1'b1;
            state_d = C_IDLE;
          end else begin
            rem_d   = part5;
            span_d  = span;
            quo_d   = '0;
            k_d     = 2'd2;
            state_d = C_DIV;
          end
        end else begin
          acc_d = acc_q + PctSegment;
          lo_d  = hi;
          idx_d = idx_q + 1'b1;
        end
      end
      C_DIV: begin
        if (rem_q >= shifted) begin
          rem_d      = rem_q - shifted;
          quo_d[k_q] = 1'b1;
        end
        k_d = k_q - 1'b1;
        if (k_q == 2'd0) begin
          pct_d   = acc_q + {4'd0, quo_d};
          done_d  = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    lo_q   <= lo_d;
    span_q <= span_d;
    acc_q  <= acc_d;
    pct_q  <= pct_d;
    idx_q  <= idx_d;
    prof_q <= prof_d;
    chg_q  <= chg_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    k_q    <= k_d;
  end

  assign done_o = done_q;
  assign pct_o  = pct_q;

endmodule

`default_nettype wire

[src/battery_charge_percent_tracker_top.sv]
// Flow from accepted beat to result beat: restart, unknown status, invalid or full voltage go
//   straight to the done state; the discharge curve walks segments, then divides if the span is not zero.
// Charging: stall check, elapsed-time add, then a loop of percent steps; a stall recovery
//   walks the charge curve but clears the elapsed time, so its loop takes no percent step.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: asynchronous active low; state reloads as after a restart with reset registers.
// ----------------------------------------------------------------------------
// Battery charge percent tracker top level
// Tracks reported battery percentage from charge status, voltage and time.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_percent_tracker_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_addr_i,
  input  wire  [7:0]  cfg_wdata_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // charge_status[1:0], cell_mv[17:2], delta_sec[49:18]
  input  wire  [55:0] s_axis_tdata,
  // func[0]
  input  wire         s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // percent_out[6:0], full_count_out[10:7]
  output logic [15:0] m_axis_tdata,
  // accepted[0]
  output logic        m_axis_tuser
);
  import bcpt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_STALL   = 7'b0000010,
    S_CURVE_D = 7'b0000100,
    S_CURVE_C = 7'b0001000,
    S_ADD     = 7'b0010000,
    S_LOOP    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] btype_q, btype_d;
  logic [6:0] ipct_q, ipct_d;
  logic [1:0] ichg_q, ichg_d;

  logic [1:0]  last_q, last_d;
  logic [6:0]  rep_q, rep_d, pp_q, pp_d, blpct_q, blpct_d;
  logic [3:0]  rc_q, rc_d;
  logic [10:0] ps_q, ps_d;
  logic        hb_q, hb_d, rec_q, rec_d, ok_q, ok_d;
  logic [15:0] blmv_q, blmv_d, mv_q, mv_d;
  logic [31:0] unch_q, unch_d;
  logic [7:0]  take_q, take_d;

  logic        ovalid_q, ovalid_d, oacc_q, oacc_d;
  logic [6:0]  opct_q, opct_d;
  logic [3:0]  ofc_q, ofc_d;

  logic        fire, in_func, valid_type, cur_dn, recover;
  logic [1:0]  in_chg;
  logic [15:0] in_mv;
  logic [31:0] in_el;
  logic [3:0]  rc_new;
  logic [ProfW-1:0] curve_prof, cad_prof;
  logic [1:0]  band;
  logic [8:0]  need;
  logic [16:0] bl_rise;
  curve_req_t  creq;
  logic        cdone;
  logic [6:0]  cpct, crep;

  assign in_func = s_axis_tuser;
  assign in_chg  = s_axis_tdata[1:0];
  assign in_mv   = s_axis_tdata[17:2];
  assign in_el   = s_axis_tdata[49:18];

  assign s_axis_tready = (state_q == S_IDLE);
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign valid_type = (btype_q >= 8'd1) && (btype_q <= 8'(ProfileCount));
  assign curve_prof = valid_type ? ProfW'(btype_q - 8'd1) : ProfW'(ProfileCount - 1);
  assign cad_prof   = valid_type ? ProfW'(btype_q - 8'd1) : '0;

  assign rc_new = (in_chg != ChgFull) ? 4'd0 :
                  (rc_q < RefreshSat) ? rc_q + 4'd1 : RefreshSat;

  // discharge path needs the curve unless invalid voltage, or full voltage with enough full reports, settles it
  assign cur_dn = (in_mv > MvInvalidMax) && !((in_mv >= MvFullMin) && (rc_new >= FullReports));

  assign bl_rise = {1'b0, blmv_q} + {1'b0, StallRise};
  assign recover = !rec_q && (rep_q <= StallPctMax) && (blmv_q >= StallMvMin) &&
                   (mv_q >= StallMvMin) && ({1'b0, mv_q} >= bl_rise) &&
                   (unch_q >= StallSeconds);

  always_comb begin
    creq.prof = curve_prof;
    creq.charging = (state_q == S_STALL);
    creq.mv = (state_q == S_STALL) ? mv_q : in_mv;
    creq.start = 1'b0;
    if (state_q == S_IDLE) begin
      creq.start = fire && !in_func && (in_chg != ChgUnknown) && (in_chg != ChgActive) &&
                   cur_dn;
    end else if (state_q == S_STALL) begin
      creq.start = (rep_q != 7'd0) && hb_q && (rep_q == blpct_q) && recover;
    end
  end

  bcpt_curve u_curve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .done_o (cdone),
    .pct_o  (cpct)
  );

  assign crep = (cpct < rep_q) ? rep_q : ((cpct > PctFull) ? PctFull : cpct);

  always_comb begin
    if (pp_q < BandOne) begin
      band = 2'd0;
    end else if (pp_q < BandTwo) begin
      band = 2'd1;
    end else if (pp_q < BandThree) begin
      band = 2'd2;
    end else begin
      band = 2'd3;
    end
    need = StepTab[cad_prof][band];
  end

  always_comb begin
    state_d  = state_q;
    btype_d  = btype_q;
    ipct_d   = ipct_q;
    ichg_d   = ichg_q;
    last_d   = last_q;
    rep_d    = rep_q;
    pp_d     = pp_q;
    blpct_d  = blpct_q;
    rc_d     = rc_q;
    ps_d     = ps_q;
    hb_d     = hb_q;
    rec_d    = rec_q;
    ok_d     = ok_q;
    blmv_d   = blmv_q;
    mv_d     = mv_q;
    unch_d   = unch_q;
    take_d   = take_q;
    ovalid_d = ovalid_q;
    oacc_d   = oacc_q;
    opct_d   = opct_q;
    ofc_d    = ofc_q;

    if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegBatteryType:    btype_d = cfg_wdata_i;
        RegInitialPercent: ipct_d  = cfg_wdata_i[6:0];
        RegInitialCharge:  ichg_d  = cfg_wdata_i[1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (fire) begin
          mv_d = in_mv;
          ok_d = 1'b1;
          if (in_func) begin
            last_d  = ichg_q;
            rep_d   = ipct_q;
            rc_d    = '0;
            pp_d    = ipct_q;
            ps_d    = '0;
            hb_d    = 1'b0;
            blpct_d = '0;
            blmv_d  = '0;
            rec_d   = 1'b0;
            unch_d  = '0;
            state_d = S_DONE;
          end else if (in_chg == ChgUnknown) begin
            ok_d    = 1'b0;
            state_d = S_DONE;
          end else begin
            rc_d   = rc_new;
            last_d = in_chg;
            if (in_chg != ChgActive) begin
              pp_d   = '0;
              ps_d   = '0;
              hb_d   = 1'b0;
              rec_d  = 1'b0;
              unch_d = '0;
              if (in_mv <= MvInvalidMax) begin
                rep_d   = PctInvalid;
                state_d = S_DONE;
              end else if (!cur_dn) begin
                rep_d   = PctFull;
                state_d = S_DONE;
              end else begin
                state_d = S_CURVE_D;
              end
            end else begin
              if (last_q != ChgActive) begin
                pp_d   = (rep_q == 7'd0) ? 7'd1 : rep_q;
                ps_d   = '0;
                hb_d   = 1'b0;
                rec_d  = 1'b0;
                unch_d = '0;
                take_d = '0;
              end else begin
                // saturate the unchanged-time counter
                unch_d = (~unch_q < in_el) ? '1 : unch_q + in_el;
                take_d = (in_el >= {24'd0, ElapsedLimit}) ? ElapsedLimit : in_el[7:0];
              end
              state_d = S_STALL;
            end
          end
        end
      end
      S_STALL: begin
        state_d = S_ADD;
        if (rep_q != 7'd0) begin
          if (!hb_q || (rep_q != blpct_q)) begin
            hb_d    = 1'b1;
            blpct_d = rep_q;
            blmv_d  = mv_q;
            rec_d   = 1'b0;
            unch_d  = '0;
          end else if (recover) begin
            state_d = S_CURVE_C;
          end
        end
      end
      S_CURVE_D: begin
        if (cdone) begin
          rep_d   = cpct;
          state_d = S_DONE;
        end
      end
      S_CURVE_C: begin
        if (cdone) begin
          blmv_d  = mv_q;
          rec_d   = 1'b1;
          unch_d  = '0;
          pp_d    = crep;
          ps_d    = '0;
          take_d  = '0;
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (pp_q >= PctFull) begin
          rep_d   = PctFull;
          state_d = S_DONE;
        end else begin
          ps_d    = ps_q + {3'd0, take_q};
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if ((pp_q < PctFull) && (ps_q != 11'd0) && (ps_q >= {2'd0, need})) begin
          ps_d = ps_q - {2'd0, need};
          pp_d = pp_q + 7'd1;
        end else begin
          ps_d    = {1'b0, ps_q[9:0]};
          rep_d   = ((mv_q >= MvFullMin) && (rc_q >= FullReports)) ? PctFull : pp_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          oacc_d   = ok_q;
          opct_d   = rep_q;
          ofc_d    = rc_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      btype_q  <= 8'd1;
      ipct_q   <= '0;
      ichg_q   <= ChgNone;
      last_q   <= ChgNone;
      rep_q    <= '0;
      pp_q     <= '0;
      blpct_q  <= '0;
      rc_q     <= '0;
      ps_q     <= '0;
      hb_q     <= 1'b0;
      rec_q    <= 1'b0;
      blmv_q   <= '0;
      unch_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      btype_q  <= btype_d;
      ipct_q   <= ipct_d;
      ichg_q   <= ichg_d;
      last_q   <= last_d;
      rep_q    <= rep_d;
      pp_q     <= pp_d;
      blpct_q  <= blpct_d;
      rc_q     <= rc_d;
      ps_q     <= ps_d;
      hb_q     <= hb_d;
      rec_q    <= rec_d;
      blmv_q   <= blmv_d;
      unch_q   <= unch_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    mv_q   <= mv_d;
    take_q <= take_d;
    oacc_q <= oacc_d;
    opct_q <= opct_d;
    ofc_q  <= ofc_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, ofc_q, opct_q};
  assign m_axis_tuser  = oacc_q;

endmodule

`default_nettype wire

[test/tb_battery_charge_percent_tracker_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery charge percent tracker testbench
// Drives update and restart beats with random gaps, predicts each result from
// a local copy of the tracker state and compares every returned beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_battery_charge_percent_tracker_top;
  import bcpt_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  // index past the register list
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic       accepted;
    logic [3:0] full_count;
    logic [6:0] percent;
  } tracker_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic cfg_ready_o;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tuser;

  always #10 clk_i = ~clk_i;

  battery_charge_percent_tracker_top uut (.*);

  // predictor state
  logic [7:0]  pr_type;
  logic [6:0]  pr_init_pct;
  logic [1:0]  pr_init_chg;
  logic [1:0]  st_last_charge;
  logic [6:0]  st_reported;
  logic [3:0]  st_refresh;
  logic [6:0]  st_progress;
  logic [9:0]  st_prog_sec;
  logic        st_has_base;
  logic [6:0]  st_base_pct;
  logic [15:0] st_base_mv;
  logic        st_recovered;
  logic [31:0] st_unchanged;

  tracker_out_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet_mode = 0;

  function automatic int unsigned profile_curve();
    if (pr_type >= 1 && pr_type <= ProfileCount) return pr_type - 1;
    return ProfileCount - 1;
  endfunction

  function automatic int unsigned profile_cadence();
    if (pr_type >= 1 && pr_type <= ProfileCount) return pr_type - 1;
    return 0;
  endfunction

  function automatic logic [6:0] curve_lookup(bit charging, logic [15:0] mv_in);
    int unsigned p, v, lo, acc, hi, span, part, lastub;
    p = profile_curve();
    lastub = charging ? ChgTab[p][CurveSegments-1] : DisTab[p][CurveSegments-1];
    v = mv_in;
    lo = MvCurveFloor;
    acc = 0;
    if (v < MvCurveFloor) v = MvCurveFloor;
    if (v > lastub) v = lastub;
    for (int i = 0; i < CurveSegments; i++) begin
      hi = charging ? ChgTab[p][i] : DisTab[p][i];
      if (v <= hi) begin
        span = (hi >= lo) ? hi - lo : 0;
        part = (v >= lo) ? v - lo : 0;
        if (span == 0) return acc[6:0];
        return 7'((acc + (5 * part) / span) & 'h7f);
      end
      acc += 5;
      lo = hi;
    end
    return acc[6:0];
  endfunction

  task automatic reload_tracker();
    st_last_charge = pr_init_chg;
    st_reported = pr_init_pct;
    st_refresh = 0;
    st_progress = pr_init_pct;
    st_prog_sec = 0;
    st_has_base = 0;
    st_base_pct = 0;
    st_base_mv = 0;
    st_recovered = 0;
    st_unchanged = 0;
  endtask

  task automatic track_update(logic func, logic [1:0] chg, logic [15:0] mv, logic [31:0] el);
    tracker_out_t res;
    bit entering;
    int unsigned take, secs, need, band, rep, pp;
    res.accepted = 1'b1;
    if (func) begin
      reload_tracker();
    end else if (chg == ChgUnknown) begin
      res.accepted = 1'b0;
    end else begin
      entering = (st_last_charge != ChgActive) && (chg == ChgActive);
      if (chg != ChgFull) st_refresh = 0;
      else if (st_refresh < RefreshSat) st_refresh++;
      else st_refresh = RefreshSat;
      st_last_charge = chg;
      if (chg != ChgActive) begin
        st_progress = 0;
        st_prog_sec = 0;
        st_has_base = 0;
        st_recovered = 0;
        st_unchanged = 0;
        if (mv <= MvInvalidMax) st_reported = PctInvalid;
        else if (mv >= MvFullMin && st_refresh >= FullReports) st_reported = PctFull;
        else st_reported = curve_lookup(0, mv);
      end else begin
        take = el;
        if (entering) begin
          st_progress = (st_reported == 0) ? 7'd1 : st_reported;
          st_prog_sec = 0;
          st_has_base = 0;
          st_recovered = 0;
          st_unchanged = 0;
          take = 0;
        end
        if (32'hffff_ffff - st_unchanged < take) st_unchanged = 32'hffff_ffff;
        else st_unchanged += take;
        // stall watch: rebase on a new percent, recover once on a voltage rise
        if (st_reported != 0) begin
          if (!st_has_base || st_reported != st_base_pct) begin
            st_has_base = 1;
            st_base_pct = st_reported;
            st_base_mv = mv;
            st_recovered = 0;
            st_unchanged = 0;
          end else if (!(st_recovered || st_reported > StallPctMax ||
                         st_base_mv < StallMvMin || mv < StallMvMin ||
                         32'(mv) < 32'(st_base_mv) + 35 ||
                         st_unchanged < StallSeconds)) begin
            rep = curve_lookup(1, mv);
            if (rep < st_reported) rep = st_reported;
            if (rep > 100) rep = 100;
            st_base_mv = mv;
            st_recovered = 1;
            st_unchanged = 0;
            st_progress = 7'(rep);
            st_prog_sec = 0;
            take = 0;
          end
        end
        if (st_progress >= 100) begin
          st_reported = PctFull;
        end else begin
          secs = st_prog_sec + ((take < ElapsedLimit) ? take : ElapsedLimit);
          pp = st_progress;
          while (pp < 100 && secs != 0) begin
            band = (pp < BandOne) ? 0 : (pp < BandTwo) ? 1 : (pp < BandThree) ? 2 : 3;
            need = StepTab[profile_cadence()][band];
            if (need == 0 || secs < need) break;
            secs -= need;
            pp++;
          end
          st_progress = pp[6:0];
          st_prog_sec = secs[9:0];
          if (mv >= MvFullMin && st_refresh >= FullReports) st_reported = PctFull;
          else st_reported = st_progress;
        end
      end
    end
    res.percent = st_reported;
    res.full_count = st_refresh;
    expected_results.push_back(res);
  endtask

  task automatic random_gap(int unsigned heavy);
    int unsigned n;
    if (quiet_mode) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, heavy) : $urandom_range(0, 2);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_reading(logic func, logic [1:0] chg, logic [15:0] mv, logic [31:0] el);
    random_gap(30);
    track_update(func, chg, mv, el);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {6'd0, el, mv, chg};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    // let the drop settle before the next beat is driven
    @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegBatteryType:    pr_type = val;
      RegInitialPercent: pr_init_pct = val[6:0];
      RegInitialCharge:  pr_init_chg = val[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // result checker and sink stall
  always @(posedge clk_i) begin
    tracker_out_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got.accepted = m_axis_tuser;
      got.percent = m_axis_tdata[6:0];
      got.full_count = m_axis_tdata[10:7];
      if (expected_results.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.accepted !== exp_r.accepted) begin
          $error("accepted: expected %0d got %0d", exp_r.accepted, got.accepted);
          errors++;
        end
        if (got.percent !== exp_r.percent) begin
          $error("percent_out: expected %0d got %0d", exp_r.percent, got.percent);
          errors++;
        end
        if (got.full_count !== exp_r.full_count) begin
          $error("full_count_out: expected %0d got %0d", exp_r.full_count, got.full_count);
          errors++;
        end
      end
    end
    if (quiet_mode) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 3) != 0) m_axis_tready <= 1'b1;
  end

  // watchdog on beats moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [15:0] pick_mv();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(2380, 2420));
      2: return 16'($urandom_range(4330, 4360));
      default: return 16'($urandom_range(3300, 4360));
    endcase
  endfunction

  function automatic logic [31:0] pick_el();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'hffff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 5);
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  task automatic test_directed();
    send_reading(0, ChgNone, 16'd0, 32'd0);
    send_reading(0, ChgNone, 16'd2399, 32'd0);
    send_reading(0, ChgNone, 16'd2400, 32'd0);
    send_reading(0, ChgNone, 16'hffff, 32'hffff_ffff);
    send_reading(0, ChgUnknown, 16'hffff, 32'hffff_ffff);
    for (int i = 0; i < 6; i++) send_reading(0, ChgFull, 16'd4341, 32'd10);
    send_reading(0, ChgActive, 16'd3700, 32'd500);
    send_reading(0, ChgActive, 16'd3700, 32'hffff_ffff);
    send_reading(0, ChgActive, 16'd3700, 32'hffff_ffff);
    send_reading(0, ChgActive, 16'd3700, 32'd0);
    send_reading(0, ChgActive, 16'd4200, 32'd100);
    send_reading(0, ChgActive, 16'd4200, 32'd100);
    send_reading(1, ChgUnknown, 16'hffff, 32'hffff_ffff);
    send_reading(0, ChgNone, 16'd3350, 32'd0);
    drain_results();
  endtask

  task automatic test_registers();
    write_register(RegBatteryType, 8'd0);
    write_register(RegInitialPercent, 8'd127);
    write_register(RegInitialCharge, 8'd1);
    write_register(RegUnused, 8'hff);
    send_reading(1, ChgNone, 16'd0, 32'd0);
    send_reading(0, ChgActive, 16'd4000, 32'd200);
    send_reading(1, ChgNone, 16'd0, 32'd0);
    send_reading(0, ChgUnknown, 16'd4000, 32'd200);
    send_reading(0, ChgNone, 16'd4000, 32'd0);
    drain_results();
    write_register(RegBatteryType, 8'd255);
    write_register(RegInitialPercent, 8'd100);
    write_register(RegInitialCharge, 8'd2);
    send_reading(1, ChgNone, 16'd0, 32'd0);
    send_reading(0, ChgActive, 16'd4320, 32'd600);
    send_reading(0, ChgNone, 16'd3900, 32'd0);
    drain_results();
  endtask

  // random beats, restarts, full-status runs and charging sessions while the voltage climbs
  task automatic test_random(int unsigned count);
    int unsigned n;
    logic [15:0] mv;
    n = 0;
    while (n < count) begin
      if (n % 200 == 0) begin
        drain_results();
        quiet_mode = ($urandom_range(0, 3) == 0);
        write_register(RegBatteryType, ($urandom_range(0, 3) == 0) ? 8'($urandom()) :
                       8'($urandom_range(1, 4)));
        write_register(RegInitialPercent, 8'($urandom_range(0, 127)));
        write_register(RegInitialCharge, 8'($urandom_range(0, 3)));
      end
      case ($urandom_range(0, 9))
        0: begin
          send_reading(1, 2'($urandom()), 16'($urandom()), $urandom());
          n++;
        end
        1, 2, 3: begin
          mv = 16'($urandom_range(3700, 4300));
          send_reading(0, ChgNone, mv, 0);
          n++;
          for (int k = $urandom_range(2, 12); k > 0; k--) begin
            mv = mv + 16'($urandom_range(0, 20));
            send_reading(0, ChgActive, mv, ($urandom_range(0, 2) == 0) ?
                         $urandom_range(0, 40) : $urandom_range(60, 200));
            n++;
          end
        end
        4: begin
          for (int k = $urandom_range(4, 9); k > 0; k--) begin
            send_reading(0, ChgFull, pick_mv(), pick_el());
            n++;
          end
        end
        default: begin
          send_reading(0, 2'($urandom()), pick_mv(), pick_el());
          n++;
        end
      endcase
    end
    quiet_mode = 0;
  endtask

  initial begin
    pr_type = 8'd1;
    pr_init_pct = 0;
    pr_init_chg = 0;
    reload_tracker();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_random(1400);
    drain_results();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
